@@ sv/rcm_pkg.sv @@
// rcm_pkg: shared constants, codes and control structs for row_correlation_matrix
// no dependencies; used by rcm_ctrl, rcm_dp and row_correlation_matrix
`timescale 1ns / 1ps

package rcm_pkg;

  // matrix geometry and field widths
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 8;
  localparam int SAMPLE_W = 16;
  localparam int NROW_W   = 7;
  localparam int NCOL_W   = 9;
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int CORR_W   = 16;
  localparam int STAT_W   = 2;

  // sequencer step counts
  localparam int CNT_W        = 9;
  localparam int DRAIN_CYC    = 3;
  localparam int MUL_STEPS    = 6;
  localparam int DIV_STEPS    = 31;
  localparam int SQRT_STEPS   = 16;

  // register map
  localparam int ADDR_BITS = 3;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DRAIN,
    S_VMUL,
    S_VSUB,
    S_CHECK,
    S_MULP,
    S_MULM,
    S_DIV,
    S_SQRT,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic             load;
    logic             wr;
    logic             clr_acc;
    logic             issue;
    logic [COL_W-1:0] col;
    logic             var_mul;
    logic             var_sub;
    logic             mul_start;
    logic             mul_src_m;
    logic             mul_step;
    logic             div_start;
    logic             div_step;
    logic             sqrt_start;
    logic             sqrt_step;
  } dp_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic var_zero;
  } dp_stat_t;

endpackage

@@ sv/rcm_dp.sv @@
// rcm_dp: sample store, column sums, variance terms, serial multiplier,
// divider and square root for the correlation datapath; uses rcm_pkg
`timescale 1ns / 1ps

module rcm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rcm_pkg::dp_cmd_t                    cmd_i,
  input  logic                                func_i,
  input  logic [rcm_pkg::ROW_W-1:0]           row_i,
  input  logic [rcm_pkg::COL_W-1:0]           col_i,
  input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [rcm_pkg::ROW_W-1:0]           other_row_i,
  input  logic [rcm_pkg::NROW_W-1:0]          nrows_i,
  input  logic [rcm_pkg::NCOL_W-1:0]          ncols_i,
  output rcm_pkg::dp_stat_t                   stat_o,
  output logic [rcm_pkg::CORR_W-1:0]          corr_o
);

  // sample store, written on accepted write words
  logic [rcm_pkg::SAMPLE_W-1:0] mem [rcm_pkg::DEPTH];
  logic [rcm_pkg::ROW_W-1:0]    ra_q, rb_q;
  logic signed [15:0]           da_q, db_q, da2_q, db2_q;
  logic                         v1_q, v2_q;
  logic signed [31:0]           paa_q, pbb_q, pab_q;

  logic [38:0]        saa_q, sbb_q;
  logic signed [39:0] sab_q;
  logic signed [23:0] sa_q, sb_q;

  logic [47:0]        nsaa, nsbb, nsaa_q, nsbb_q;
  logic signed [47:0] sa2, sb2, sasb, sa2_q, sb2_q, sasb_q;
  logic signed [49:0] nsab, nsab_q, num_q, num_d;
  logic [46:0]        va_q, vb_q;
  logic [47:0]        va_d, vb_d, mag;

  logic [47:0] mul_a_q, mul_b_q;
  logic [95:0] acc_q;
  logic [55:0] pp;
  logic [92:0] prod_q;

  logic [122:0] rem_q, dvs_q;
  logic [30:0]  quo_q;
  logic         div_ge;

  logic [31:0] rad_q;
  logic [15:0] root_q;
  logic [19:0] srem_q, srem_n, trial;
  logic        sq_ge;

  logic [16:0] qsum;
  logic [15:0] qmag;

  // range check on the incoming word
  always_comb begin
    stat_o.range_bad = ({1'b0, row_i} >= nrows_i) ||
                       (func_i ? ({1'b0, other_row_i} >= nrows_i)
                               : ({1'b0, col_i} >= ncols_i));
    stat_o.var_zero  = (va_q == '0) || (vb_q == '0);
  end

  // capture query rows
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ra_q <= row_i;
      rb_q <= other_row_i;
    end
  end

  // store write and two-port row read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[{row_i, col_i}] <= sample_i;
    end
    if (cmd_i.issue) begin
      da_q <= mem[{ra_q, cmd_i.col}];
      db_q <= mem[{rb_q, cmd_i.col}];
    end
  end

  // read and product pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // per-column products
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      paa_q <= da_q * da_q;
      pbb_q <= db_q * db_q;
      pab_q <= da_q * db_q;
      da2_q <= da_q;
      db2_q <= db_q;
    end
  end

  // column sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_acc) begin
      sa_q  <= '0;
      sb_q  <= '0;
      saa_q <= '0;
      sbb_q <= '0;
      sab_q <= '0;
    end else if (v2_q) begin
      sa_q  <= sa_q + {{8{da2_q[15]}}, da2_q};
      sb_q  <= sb_q + {{8{db2_q[15]}}, db2_q};
      saa_q <= saa_q + {7'b0, paa_q};
      sbb_q <= sbb_q + {7'b0, pbb_q};
      sab_q <= sab_q + {{8{pab_q[31]}}, pab_q};
    end
  end

  // scaled sums and squared sums
  assign nsaa = ncols_i * saa_q;
  assign nsbb = ncols_i * sbb_q;
  assign sa2  = sa_q * sa_q;
  assign sb2  = sb_q * sb_q;
  assign sasb = sa_q * sb_q;
  assign nsab = $signed({1'b0, ncols_i}) * sab_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.var_mul) begin
      nsaa_q <= nsaa;
      nsbb_q <= nsbb;
      sa2_q  <= sa2;
      sb2_q  <= sb2;
      sasb_q <= sasb;
      nsab_q <= nsab;
    end
  end

  // variances and covariance numerator
  assign va_d  = nsaa_q - sa2_q;
  assign vb_d  = nsbb_q - sb2_q;
  assign num_d = nsab_q - {{2{sasb_q[47]}}, sasb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.var_sub) begin
      va_q  <= va_d[46:0];
      vb_q  <= vb_d[46:0];
      num_q <= num_d;
    end
  end

  assign mag = num_q[49] ? 48'(-num_q) : num_q[47:0];

  // serial multiplier, one byte of b per step from the top
  assign pp = mul_a_q * mul_b_q[47:40];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      acc_q <= '0;
      if (cmd_i.mul_src_m) begin
        mul_a_q <= mag;
        mul_b_q <= mag;
        prod_q  <= acc_q[92:0];
      end else begin
        mul_a_q <= {1'b0, va_q};
        mul_b_q <= {1'b0, vb_q};
      end
    end else if (cmd_i.mul_step) begin
      acc_q   <= {acc_q[87:0], 8'b0} + {40'b0, pp};
      mul_b_q <= {mul_b_q[39:0], 8'b0};
    end
  end

  // restoring divider: mag^2 * 2^30 / (va * vb)
  assign div_ge = (rem_q >= dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= {acc_q[92:0], 30'b0};
      dvs_q <= {prod_q, 30'b0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= {1'b0, dvs_q[122:1]};
      quo_q <= {quo_q[29:0], div_ge};
    end
  end

  // digit-by-digit integer square root of the quotient
  assign srem_n = {srem_q[17:0], rad_q[31:30]};
  assign trial  = {2'b0, root_q, 2'b01};
  assign sq_ge  = (srem_n >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= {1'b0, quo_q};
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sq_ge ? (srem_n - trial) : srem_n;
      root_q <= {root_q[14:0], sq_ge};
      rad_q  <= {rad_q[29:0], 2'b0};
    end
  end

  // halving the root, rounded up at the half, gives the magnitude
  assign qsum   = {1'b0, root_q} + 17'd1;
  assign qmag   = qsum[16:1];
  assign corr_o = num_q[49] ? (~qmag + 16'd1) : qmag;

endmodule

@@ sv/rcm_ctrl.sv @@
// rcm_ctrl: sequencer for writes and correlation queries
// uses rcm_pkg; drives rcm_dp through dp_cmd_t and reads dp_stat_t
`timescale 1ns / 1ps

module rcm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [rcm_pkg::NCOL_W-1:0] ncols_i,
  input  logic                       out_free_i,
  input  rcm_pkg::dp_stat_t          stat_i,
  output rcm_pkg::dp_cmd_t           cmd_o,
  output logic                       emit_o,
  output rcm_pkg::status_e           res_status_o,
  output logic                       res_corr_o
);

  rcm_pkg::state_e            state_q, state_d;
  logic [rcm_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  rcm_pkg::status_e           res_q, res_d;
  logic                       corr_en_q, corr_en_d;
  logic                       accept;

  assign accept = in_valid_i && (state_q == rcm_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q + 9'd1;
    res_d     = res_q;
    corr_en_d = corr_en_q;
    case (state_q)
      rcm_pkg::S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d   = rcm_pkg::S_RESULT;
          corr_en_d = 1'b0;
          res_d     = rcm_pkg::ST_OK;
          if (stat_i.range_bad) begin
            res_d = rcm_pkg::ST_RANGE;
          end else if (func_i) begin
            corr_en_d = 1'b1;
            state_d   = (ncols_i == '0) ? rcm_pkg::S_DRAIN : rcm_pkg::S_SUM;
          end
        end
      end
      rcm_pkg::S_SUM: begin
        if (cnt_q == ncols_i - 9'd1) begin
          state_d = rcm_pkg::S_DRAIN;
          cnt_d   = '0;
        end
      end
      rcm_pkg::S_DRAIN: begin
        if (cnt_q == rcm_pkg::CNT_W'(rcm_pkg::DRAIN_CYC - 1)) begin
          state_d = rcm_pkg::S_VMUL;
        end
      end
      rcm_pkg::S_VMUL: state_d = rcm_pkg::S_VSUB;
      rcm_pkg::S_VSUB: state_d = rcm_pkg::S_CHECK;
      rcm_pkg::S_CHECK: begin
        cnt_d = '0;
        if (stat_i.var_zero) begin
          state_d   = rcm_pkg::S_RESULT;
          res_d     = rcm_pkg::ST_ZERO_VAR;
          corr_en_d = 1'b0;
        end else begin
          state_d = rcm_pkg::S_MULP;
        end
      end
      rcm_pkg::S_MULP: begin
        if (cnt_q == rcm_pkg::CNT_W'(rcm_pkg::MUL_STEPS - 1)) begin
          state_d = rcm_pkg::S_MULM;
          cnt_d   = '0;
        end
      end
      rcm_pkg::S_MULM: begin
        if (cnt_q == rcm_pkg::CNT_W'(rcm_pkg::MUL_STEPS)) begin
          state_d = rcm_pkg::S_DIV;
          cnt_d   = '0;
        end
      end
      rcm_pkg::S_DIV: begin
        if (cnt_q == rcm_pkg::CNT_W'(rcm_pkg::DIV_STEPS)) begin
          state_d = rcm_pkg::S_SQRT;
          cnt_d   = '0;
        end
      end
      rcm_pkg::S_SQRT: begin
        if (cnt_q == rcm_pkg::CNT_W'(rcm_pkg::SQRT_STEPS)) begin
          state_d = rcm_pkg::S_RESULT;
        end
      end
      rcm_pkg::S_RESULT: begin
        if (out_free_i) begin
          state_d = rcm_pkg::S_IDLE;
        end
      end
      default: state_d = rcm_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    emit_o       = 1'b0;
    res_status_o = res_q;
    res_corr_o   = corr_en_q;
    case (state_q)
      rcm_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load    = accept;
        cmd_o.clr_acc = accept;
        cmd_o.wr      = accept && !func_i && !stat_i.range_bad;
      end
      rcm_pkg::S_SUM: begin
        cmd_o.issue = 1'b1;
        cmd_o.col   = cnt_q[rcm_pkg::COL_W-1:0];
      end
      rcm_pkg::S_VMUL:  cmd_o.var_mul = 1'b1;
      rcm_pkg::S_VSUB:  cmd_o.var_sub = 1'b1;
      rcm_pkg::S_CHECK: cmd_o.mul_start = !stat_i.var_zero;
      rcm_pkg::S_MULP:  cmd_o.mul_step = 1'b1;
      rcm_pkg::S_MULM: begin
        cmd_o.mul_src_m = 1'b1;
        cmd_o.mul_start = (cnt_q == '0);
        cmd_o.mul_step  = (cnt_q != '0);
      end
      rcm_pkg::S_DIV: begin
        cmd_o.div_start = (cnt_q == '0);
        cmd_o.div_step  = (cnt_q != '0);
      end
      rcm_pkg::S_SQRT: begin
        cmd_o.sqrt_start = (cnt_q == '0);
        cmd_o.sqrt_step  = (cnt_q != '0);
      end
      rcm_pkg::S_RESULT: emit_o = out_free_i;
      default: cmd_o = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rcm_pkg::S_IDLE;
      cnt_q     <= '0;
      res_q     <= rcm_pkg::ST_OK;
      corr_en_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      res_q     <= res_d;
      corr_en_q <= corr_en_d;
    end
  end

`ifndef SYNTHESIS
  // column reads stay inside the columns in use
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> ({1'b0, cmd_o.col} < ncols_i))
    else $error("column read beyond columns in use");

  // a result word always returns the sequencer to idle
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |=> (state_q == rcm_pkg::S_IDLE))
    else $error("sequencer not idle after result");

  // store writes happen only on an accepted word
  a_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr |-> (in_valid_i && in_ready_o))
    else $error("store write without accepted word");

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != rcm_pkg::S_IDLE))
    else $error("accepted word did not start work");
`endif

endmodule

@@ sv/row_correlation_matrix.sv @@
// row_correlation_matrix: top level with config registers and output register
// depends on rcm_pkg, rcm_ctrl and rcm_dp
//
//   channel   direction  handshake             payload
//   in        input      in_valid/in_ready     func, row, col, sample, other_row
//   out       output     out_valid/out_ready   correlation, status
//   apb       input      psel/penable/pready   paddr, pwdata, prdata
//
// a write word is stored when it is accepted; a query reads the store once per
// column and then runs the serial multiply, bit-serial divide and square root steps.
// one word is worked at a time; the next word is taken while a result waits.
// reset clears control and sets rows 64, cols 256; store contents undefined.
`timescale 1ns / 1ps

module row_correlation_matrix (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcm_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [rcm_pkg::ROW_W-1:0]           row_i,
  input  logic [rcm_pkg::COL_W-1:0]           col_i,
  input  logic signed [rcm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [rcm_pkg::ROW_W-1:0]           other_row_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rcm_pkg::CORR_W-1:0]   correlation_o,
  output logic [rcm_pkg::STAT_W-1:0]          status_o
);

  logic [rcm_pkg::NROW_W-1:0] rows_q, nrows;
  logic [rcm_pkg::NCOL_W-1:0] cols_q, ncols;
  logic                       cfg_wr, out_free, emit, res_corr;
  rcm_pkg::status_e           res_status;
  rcm_pkg::dp_cmd_t           cmd;
  rcm_pkg::dp_stat_t          stat;
  logic [rcm_pkg::CORR_W-1:0] corr;
  logic                       out_valid_q;
  logic [rcm_pkg::CORR_W-1:0] corr_q;
  rcm_pkg::status_e           status_q;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= rcm_pkg::NROW_W'(rcm_pkg::MAX_ROWS);
      cols_q <= rcm_pkg::NCOL_W'(rcm_pkg::MAX_COLS);
    end else if (cfg_wr) begin
      if (paddr[2] == rcm_pkg::REG_ROWS) begin
        rows_q <= pwdata[rcm_pkg::NROW_W-1:0];
      end else begin
        cols_q <= pwdata[rcm_pkg::NCOL_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == rcm_pkg::REG_COLS) ? {23'b0, cols_q} : {25'b0, rows_q};

  // sizes in use, clamped to the store
  assign nrows = (rows_q > rcm_pkg::NROW_W'(rcm_pkg::MAX_ROWS)) ?
                 rcm_pkg::NROW_W'(rcm_pkg::MAX_ROWS) : rows_q;
  assign ncols = (cols_q > rcm_pkg::NCOL_W'(rcm_pkg::MAX_COLS)) ?
                 rcm_pkg::NCOL_W'(rcm_pkg::MAX_COLS) : cols_q;

  rcm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .ncols_i      (ncols),
    .out_free_i   (out_free),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .emit_o       (emit),
    .res_status_o (res_status),
    .res_corr_o   (res_corr)
  );

  rcm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .sample_i    (sample_i),
    .other_row_i (other_row_i),
    .nrows_i     (nrows),
    .ncols_i     (ncols),
    .stat_o      (stat),
    .corr_o      (corr)
  );

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      corr_q   <= res_corr ? corr : '0;
      status_q <= res_status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign correlation_o = corr_q;
  assign status_o      = status_q;

endmodule
